/* src/cdq_pkg.sv */
// shared constants, operation codes and status type for the circular deque
package cdq_pkg;

	localparam int DATA_W            = 32;
	localparam int MODE_W            = 3;
	localparam int CAP_W             = 11;
	localparam int APB_DATA_W        = 32;
	localparam int APB_ADDR_W        = 2;
	localparam int DEFAULT_MAX_DEPTH = 1024;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HOLD       = 3'd4;

	localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef struct packed {
		logic ok;
		logic empty;
		logic full;
	} cdq_status_t;

endpackage

/* src/cdq_ring_mem.sv */
// ring store: one write port, two registered read ports
module cdq_ring_mem #(
	parameter int DEPTH = cdq_pkg::DEFAULT_MAX_DEPTH,
	parameter int AW    = $clog2(cdq_pkg::DEFAULT_MAX_DEPTH)
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic signed [cdq_pkg::DATA_W-1:0] wr_data,
	input  logic                              rd_en,
	input  logic [AW-1:0]                     rd_addr_a,
	input  logic [AW-1:0]                     rd_addr_b,
	output logic signed [cdq_pkg::DATA_W-1:0] rd_data_a,
	output logic signed [cdq_pkg::DATA_W-1:0] rd_data_b
);

	logic signed [cdq_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

/* src/cdq_ptr.sv */
// head pointer, fill count and operation decode of the circular deque
module cdq_ptr #(
	parameter int MAX_DEPTH = cdq_pkg::DEFAULT_MAX_DEPTH,
	parameter int AW        = $clog2(cdq_pkg::DEFAULT_MAX_DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             op_en,
	input  logic [cdq_pkg::MODE_W-1:0]       mode,
	input  logic [cdq_pkg::CAP_W-1:0]        capacity,
	output logic                             wr_en,
	output logic [AW-1:0]                    wr_addr,
	output logic [AW-1:0]                    front_addr,
	output logic [AW-1:0]                    rear_addr,
	output cdq_pkg::cdq_status_t             status
);

	localparam int CW   = $clog2(MAX_DEPTH + 1);
	localparam int CMPW = (CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W;
	localparam logic [AW-1:0]   LAST_POS  = AW'(MAX_DEPTH - 1);
	localparam logic [AW:0]     DEPTH_EXT = (AW + 1)'(MAX_DEPTH);
	localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(MAX_DEPTH);

	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic            ok_q;
	logic [CMPW-1:0] cap_ext;
	logic [CMPW-1:0] cap_eff;
	logic            full;
	logic            empty;
	logic [AW-1:0]   head_dec;
	logic [AW-1:0]   head_inc;
	logic            op_ok;

	// base + offset modulo the ring depth, both below the depth
	function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
		input logic [AW-1:0] offs);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, offs};
		if (sum >= DEPTH_EXT) begin
			sum = sum - DEPTH_EXT;
		end
		return sum[AW-1:0];
	endfunction

	assign cap_ext = CMPW'(capacity);
	assign cap_eff = (cap_ext > DEPTH_CMP) ? DEPTH_CMP : cap_ext;
	assign full    = CMPW'(count_q) >= cap_eff;
	assign empty   = (count_q == '0);

	assign head_dec = (head_q == '0) ? LAST_POS : head_q - 1'b1;
	assign head_inc = (head_q == LAST_POS) ? '0 : head_q + 1'b1;

	always_comb begin
		op_ok   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = ring_pos(head_q, count_q[AW-1:0]);
		case (mode)
			cdq_pkg::MODE_PUSH_FRONT: begin
				op_ok   = !full;
				wr_en   = op_en && !full;
				wr_addr = head_dec;
			end
			cdq_pkg::MODE_PUSH_REAR: begin
				op_ok = !full;
				wr_en = op_en && !full;
			end
			cdq_pkg::MODE_POP_FRONT: op_ok = !empty;
			cdq_pkg::MODE_POP_REAR:  op_ok = !empty;
			cdq_pkg::MODE_HOLD:      op_ok = 1'b1;
			default:                 op_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			ok_q    <= 1'b0;
		end else if (op_en) begin
			ok_q <= op_ok;
			if (op_ok) begin
				case (mode)
					cdq_pkg::MODE_PUSH_FRONT: begin
						head_q  <= head_dec;
						count_q <= count_q + 1'b1;
					end
					cdq_pkg::MODE_PUSH_REAR: count_q <= count_q + 1'b1;
					cdq_pkg::MODE_POP_FRONT: begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end
					cdq_pkg::MODE_POP_REAR: count_q <= count_q - 1'b1;
					default: ;
				endcase
			end
		end
	end

	// rear sits count-1 past the head; only looked at when not empty
	assign front_addr = head_q;
	assign rear_addr  = ring_pos(head_q, AW'(count_q - 1'b1));

	assign status.ok    = ok_q;
	assign status.empty = empty;
	assign status.full  = full;

endmodule

/* src/circular_deque_top.sv */
// top level of the circular deque: handshakes, sequencer, config register and result register
// Bounded double-ended queue of signed 32-bit values kept in a ring store of
// MAX_DEPTH entries. Each input transfer carries a mode (push front, push rear,
// pop front, pop rear, hold) and a value; each produces exactly one output
// transfer with the success flag, the front and rear values (-1 when empty),
// and the empty and full flags as they stand after the operation. In the accept
// cycle an item updates head and count and does the store write; state S_RD then
// reads the front and rear entries, and state S_RESP, once the result register is
// free, returns the read data from the registered memory ports into the result
// register. The result register frees the input side, so a new item is taken
// while a previous result still waits for out_ready. The capacity register
// (APB, byte address 0, reset 1024) limits the fill level and saturates at
// MAX_DEPTH; it should be written only while no transfer is in flight. The
// store needs no clearing after reset since only written entries are read.
module circular_deque_top #(
	parameter int MAX_DEPTH = cdq_pkg::DEFAULT_MAX_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [cdq_pkg::MODE_W-1:0]            mode,
	input  logic signed [cdq_pkg::DATA_W-1:0]     value,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  success,
	output logic signed [cdq_pkg::DATA_W-1:0]     front_value,
	output logic signed [cdq_pkg::DATA_W-1:0]     rear_value,
	output logic                                  is_empty,
	output logic                                  is_full,
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [cdq_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [cdq_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [cdq_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	localparam int AW = $clog2(MAX_DEPTH);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0]                        state_q;
	logic [cdq_pkg::CAP_W-1:0]         capacity_q;
	logic                              in_xfer;
	logic                              out_load;
	logic                              wr_en;
	logic [AW-1:0]                     wr_addr;
	logic [AW-1:0]                     front_addr;
	logic [AW-1:0]                     rear_addr;
	logic signed [cdq_pkg::DATA_W-1:0] rd_front;
	logic signed [cdq_pkg::DATA_W-1:0] rd_rear;
	cdq_pkg::cdq_status_t              status;

	logic                              out_valid_q;
	logic                              success_q;
	logic signed [cdq_pkg::DATA_W-1:0] front_q;
	logic signed [cdq_pkg::DATA_W-1:0] rear_q;
	logic                              empty_q;
	logic                              full_q;

	// one item in flight at a time; input opens again once the result is stored
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	// result moves to the output register once that register is free
	assign out_load = (state_q == S_RESP) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_RD;
					end
				end
				S_RD:   state_q <= S_RESP;
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pointer update and store write happen in the accept cycle
	cdq_ptr #(
		.MAX_DEPTH (MAX_DEPTH),
		.AW        (AW)
	) u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_en      (in_xfer),
		.mode       (mode),
		.capacity   (capacity_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.front_addr (front_addr),
		.rear_addr  (rear_addr),
		.status     (status)
	);

	// reads are issued in S_RD, the state after the write, so no same-entry overlap
	cdq_ring_mem #(
		.DEPTH (MAX_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (value),
		.rd_en     (state_q == S_RD),
		.rd_addr_a (front_addr),
		.rd_addr_b (rear_addr),
		.rd_data_a (rd_front),
		.rd_data_b (rd_rear)
	);

	// output register, holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			success_q <= status.ok;
			front_q   <= status.empty ? cdq_pkg::EMPTY_VALUE : rd_front;
			rear_q    <= status.empty ? cdq_pkg::EMPTY_VALUE : rd_rear;
			empty_q   <= status.empty;
			full_q    <= status.full;
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign front_value = front_q;
	assign rear_value  = rear_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

	// capacity register, written in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= cdq_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr == cdq_pkg::ADDR_CAPACITY)) begin
			capacity_q <= pwdata[cdq_pkg::CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == cdq_pkg::ADDR_CAPACITY)
		? cdq_pkg::APB_DATA_W'(capacity_q) : '0;

endmodule
